>>> hdl/swrl_pkg.sv
// swrl_pkg: shared types, constants and the microcode ROM of the rate limiter
// used by swrl_seq, swrl_datapath and sliding_window_log_rate_limiter_core
// depends on nothing
`timescale 1ns / 1ps

package swrl_pkg;

    // fixed field widths
    localparam int CLIENT_W = 4;
    localparam int TIME_W   = 32;
    localparam int MAXREQ_W = 5;
    localparam int LOGCNT_W = 5;

    // configuration register indexes and reset values
    typedef logic [0:0] cfg_idx_t;
    localparam cfg_idx_t CFG_WINDOW = 1'b0;
    localparam cfg_idx_t CFG_MAX    = 1'b1;

    localparam logic [TIME_W-1:0]   WINDOW_RESET = 32'd1000;
    localparam logic [MAXREQ_W-1:0] MAXREQ_RESET = 5'd10;

    typedef struct packed {
        logic [TIME_W-1:0]   window;
        logic [MAXREQ_W-1:0] max_req;
    } cfg_t;

    // microprogram addresses
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;
    localparam step_t STEP_CLEAR  = 3'd0;
    localparam step_t STEP_IDLE   = 3'd1;
    localparam step_t STEP_LOAD   = 3'd2;
    localparam step_t STEP_EVICT  = 3'd3;
    localparam step_t STEP_DECIDE = 3'd4;

    // jump conditions
    typedef enum logic [2:0] {
        COND_ALWAYS     = 3'd0,
        COND_START      = 3'd1,
        COND_CLR_LAST   = 3'd2,
        COND_CLIENT_OK  = 3'd3,
        COND_EVICT_MORE = 3'd4
    } cond_t;

    // datapath controls of one step
    typedef struct packed {
        logic busy;
        logic clr_wr;
        logic take;
        logic load;
        logic evict;
        logic commit;
    } ctrl_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic clr_last;
        logic client_ok;
        logic evict_more;
    } stat_t;

    typedef struct packed {
        ctrl_t ctrl;
        cond_t cond;
        step_t jmp;
        step_t nxt;
    } ucode_t;

    // control store: taken jump when cond holds, else fall to nxt
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = '0;
        unique case (step)
            STEP_CLEAR:
            begin
                w.ctrl.busy   = 1'b1;
                w.ctrl.clr_wr = 1'b1;
                w.cond        = COND_CLR_LAST;
                w.jmp         = STEP_IDLE;
                w.nxt         = STEP_CLEAR;
            end
            STEP_IDLE:
            begin
                w.ctrl.take = 1'b1;
                w.cond      = COND_START;
                w.jmp       = STEP_LOAD;
                w.nxt       = STEP_IDLE;
            end
            STEP_LOAD:
            begin
                w.ctrl.busy = 1'b1;
                w.ctrl.load = 1'b1;
                w.cond      = COND_CLIENT_OK;
                w.jmp       = STEP_EVICT;
                w.nxt       = STEP_DECIDE;
            end
            STEP_EVICT:
            begin
                w.ctrl.busy  = 1'b1;
                w.ctrl.evict = 1'b1;
                w.cond       = COND_EVICT_MORE;
                w.jmp        = STEP_EVICT;
                w.nxt        = STEP_DECIDE;
            end
            STEP_DECIDE:
            begin
                w.ctrl.busy   = 1'b1;
                w.ctrl.commit = 1'b1;
                w.cond        = COND_ALWAYS;
                w.jmp         = STEP_IDLE;
                w.nxt         = STEP_IDLE;
            end
            default:
            begin
                w.ctrl.busy = 1'b1;
                w.cond      = COND_ALWAYS;
                w.jmp       = STEP_IDLE;
                w.nxt       = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> hdl/swrl_ram.sv
// swrl_ram: generic simple dual-port RAM, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module swrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/swrl_seq.sv
// swrl_seq: microcode sequencer, step counter plus control store lookup
// depends on swrl_pkg
`timescale 1ns / 1ps

module swrl_seq
    import swrl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output ctrl_t ctrl
);

    step_t  pc_reg;
    step_t  pc_next;
    ucode_t word;
    logic   hit;

    // fetch the control word of the current step
    assign word = ucode_rom(pc_reg);
    assign ctrl = word.ctrl;

    // evaluate the jump condition
    always_comb
    begin
        unique case (word.cond)
            COND_ALWAYS:     hit = 1'b1;
            COND_START:      hit = start;
            COND_CLR_LAST:   hit = stat.clr_last;
            COND_CLIENT_OK:  hit = stat.client_ok;
            COND_EVICT_MORE: hit = stat.evict_more;
            default:         hit = 1'b0;
        endcase
        pc_next = hit ? word.jmp : word.nxt;
    end

    // step counter, starts with the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_CLEAR;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

>>> hdl/swrl_datapath.sv
// swrl_datapath: per-client ring state, timestamp log memory, eviction compare
// depends on swrl_pkg and swrl_ram
`timescale 1ns / 1ps

module swrl_datapath
    import swrl_pkg::*;
#(
    parameter int CLIENTS   = 16,
    parameter int LOG_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_t               ctrl,
    input  cfg_t                cfg,
    input  logic                start,
    input  logic [CLIENT_W-1:0] client,
    input  logic [TIME_W-1:0]   now_time,
    output stat_t               stat,
    output logic                done,
    output logic [CLIENT_W-1:0] client_echo,
    output logic                accepted,
    output logic [LOGCNT_W-1:0] logged_count
);

    localparam int CIW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int HW  = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CW  = $clog2(LOG_DEPTH + 1);
    localparam int SW  = CW + 1;
    localparam int LOG_ENTRIES = CLIENTS * LOG_DEPTH;
    localparam int LAW = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;
    localparam int STW = HW + CW;

    // control registers
    logic [CIW-1:0] clr_reg;
    logic [CIW-1:0] clr_next;
    logic           ok_reg;
    logic           ok_next;
    logic           done_reg;
    logic           done_next;

    // payload registers
    logic [CLIENT_W-1:0] client_reg;
    logic [CLIENT_W-1:0] client_next;
    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   now_next;
    logic [LAW-1:0]      base_reg;
    logic [LAW-1:0]      base_next;
    logic [HW-1:0]       head_reg;
    logic [HW-1:0]       head_next;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       cnt_next;
    logic [CLIENT_W-1:0] echo_reg;
    logic [CLIENT_W-1:0] echo_next;
    logic                acc_reg;
    logic                acc_next;
    logic [CW-1:0]       res_cnt_reg;
    logic [CW-1:0]       res_cnt_next;

    // memory ports
    logic           st_we;
    logic [CIW-1:0] st_waddr;
    logic [STW-1:0] st_wdata;
    logic [CIW-1:0] st_raddr;
    logic [STW-1:0] st_rdata;
    logic           log_we;
    logic [LAW-1:0] log_waddr;
    logic [LAW-1:0] log_raddr;
    logic [TIME_W-1:0] log_rdata;

    // datapath values
    logic [CIW-1:0]    cidx_in;
    logic              ok_in;
    logic              accept_beat;
    logic [HW-1:0]     rd_head;
    logic [CW-1:0]     rd_cnt;
    logic [HW-1:0]     head_inc;
    logic [TIME_W-1:0] age;
    logic              evict_more;
    logic              room;
    logic [SW-1:0]     slot_sum;
    logic [HW-1:0]     slot;
    logic [CW-1:0]     cnt_inc;

    // per-client ring head and count
    swrl_ram #(
        .WIDTH (STW),
        .DEPTH (CLIENTS)
    ) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // timestamp log, one ring of LOG_DEPTH entries per client
    swrl_ram #(
        .WIDTH (TIME_W),
        .DEPTH (LOG_ENTRIES)
    ) u_log_ram (
        .clk   (clk),
        .we    (log_we),
        .waddr (log_waddr),
        .wdata (now_reg),
        .raddr (log_raddr),
        .rdata (log_rdata)
    );

    // input decode
    assign cidx_in     = CIW'(client);
    assign ok_in       = (32'(client) < 32'(CLIENTS));
    assign accept_beat = ctrl.take && start;
    assign st_raddr    = cidx_in;
    assign rd_head     = st_rdata[STW-1:CW];
    assign rd_cnt      = st_rdata[CW-1:0];

    // ring step and eviction test
    assign head_inc   = (head_reg == HW'(LOG_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign age        = now_reg - log_rdata;
    assign evict_more = ctrl.evict && (cnt_reg != '0) && (age >= cfg.window);

    // admission check and free slot
    assign room     = ok_reg && (32'(cnt_reg) < 32'(LOG_DEPTH))
                      && (32'(cnt_reg) < 32'(cfg.max_req));
    assign slot_sum = SW'(head_reg) + SW'(cnt_reg);
    assign slot     = (slot_sum >= SW'(LOG_DEPTH)) ? HW'(slot_sum - SW'(LOG_DEPTH))
                                                   : HW'(slot_sum);
    assign cnt_inc  = cnt_reg + 1'b1;

    // log read address follows the ring head
    always_comb
    begin
        log_raddr = base_reg + LAW'(head_reg);
        if (ctrl.load)
        begin
            log_raddr = base_reg + LAW'(rd_head);
        end
        else if (evict_more)
        begin
            log_raddr = base_reg + LAW'(head_inc);
        end
    end

    // memory writes: clearing pass or commit
    assign log_we    = ctrl.commit && room;
    assign log_waddr = base_reg + LAW'(slot);
    assign st_we     = ctrl.clr_wr || (ctrl.commit && ok_reg);
    assign st_waddr  = ctrl.clr_wr ? clr_reg : CIW'(client_reg);
    assign st_wdata  = ctrl.clr_wr ? '0 : {head_reg, (room ? cnt_inc : cnt_reg)};

    // status to the sequencer
    assign stat.clr_last   = (clr_reg == CIW'(CLIENTS - 1));
    assign stat.client_ok  = ok_reg;
    assign stat.evict_more = evict_more;

    // next values
    always_comb
    begin
        clr_next     = ctrl.clr_wr ? clr_reg + 1'b1 : clr_reg;
        ok_next      = accept_beat ? ok_in : ok_reg;
        done_next    = ctrl.commit;
        client_next  = accept_beat ? client : client_reg;
        now_next     = accept_beat ? now_time : now_reg;
        base_next    = accept_beat ? LAW'(cidx_in * LOG_DEPTH) : base_reg;
        head_next    = head_reg;
        cnt_next     = cnt_reg;
        if (ctrl.load)
        begin
            head_next = rd_head;
            cnt_next  = rd_cnt;
        end
        else if (evict_more)
        begin
            head_next = head_inc;
            cnt_next  = cnt_reg - 1'b1;
        end
        echo_next    = echo_reg;
        acc_next     = acc_reg;
        res_cnt_next = res_cnt_reg;
        if (ctrl.commit)
        begin
            echo_next    = client_reg;
            acc_next     = room;
            res_cnt_next = room ? cnt_inc : (ok_reg ? cnt_reg : '0);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            ok_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            clr_reg  <= clr_next;
            ok_reg   <= ok_next;
            done_reg <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        client_reg  <= client_next;
        now_reg     <= now_next;
        base_reg    <= base_next;
        head_reg    <= head_next;
        cnt_reg     <= cnt_next;
        echo_reg    <= echo_next;
        acc_reg     <= acc_next;
        res_cnt_reg <= res_cnt_next;
    end

    // result beat
    assign done         = done_reg;
    assign client_echo  = echo_reg;
    assign accepted     = acc_reg;
    assign logged_count = LOGCNT_W'(res_cnt_reg);

`ifndef ASSERT_OFF
    // a result beat lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held longer than one cycle");

    // each eviction drops exactly one entry
    a_evict_one: assert property (@(posedge clk) disable iff (!rst_n)
        evict_more |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("eviction did not drop one entry");

    // an accepted request leaves a non-empty log
    a_acc_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && acc_reg) |-> (res_cnt_reg != '0))
        else $error("accepted request with empty log");

    // stored counts never exceed the ring depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (st_we && !ctrl.clr_wr) |-> (32'(st_wdata[CW-1:0]) <= 32'(LOG_DEPTH)))
        else $error("log count beyond ring depth");
`endif

endmodule

>>> hdl/sliding_window_log_rate_limiter_core.sv
// a request runs the load step, an eviction step per stale entry and one more,
// then decide; done is registered after decide, busy is high until idle, the only
// step taking a request; eviction reads one logged stamp per cycle from log memory
// a request for a client at or beyond CLIENTS skips eviction and writes no memory
// after reset a clearing pass zeroes the ring state of every client, busy held high
// results cannot be stalled: done marks one beat for exactly one cycle
`timescale 1ns / 1ps

module sliding_window_log_rate_limiter_core
    import swrl_pkg::*;
#(
    parameter int CLIENTS   = 16,
    parameter int LOG_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  cfg_idx_t            cfg_index,
    input  logic [TIME_W-1:0]   cfg_data,
    input  logic                start,
    output logic                busy,
    input  logic [CLIENT_W-1:0] client,
    input  logic [TIME_W-1:0]   now_time,
    output logic                done,
    output logic [CLIENT_W-1:0] client_echo,
    output logic                accepted,
    output logic [LOGCNT_W-1:0] logged_count
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    ctrl_t ctrl;
    stat_t stat;

    // configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WINDOW: cfg_next.window  = cfg_data;
                CFG_MAX:    cfg_next.max_req = cfg_data[MAXREQ_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window  <= WINDOW_RESET;
            cfg_reg.max_req <= MAXREQ_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // microcode sequencer
    swrl_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    assign busy = ctrl.busy;

    // datapath with log memories
    swrl_datapath #(
        .CLIENTS   (CLIENTS),
        .LOG_DEPTH (LOG_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .cfg          (cfg_reg),
        .start        (start),
        .client       (client),
        .now_time     (now_time),
        .stat         (stat),
        .done         (done),
        .client_echo  (client_echo),
        .accepted     (accepted),
        .logged_count (logged_count)
    );

endmodule
